// ===== rtl/pft2d_pkg.sv =====
// Shared types, widths, constants and the CORDIC step table for the planar pose transform.
`timescale 1ns / 1ps

package pft2d_pkg;

   // Field widths of the request and result.
   localparam int POSITION_BITS = 32;
   localparam int ANGLE_BITS    = 16;

   // Internal formats: 32-bit binary angles and Q2.30 sine and cosine.
   localparam int BAM_BITS      = 32;
   localparam int COEF_BITS     = 32;
   localparam int CORDIC_STEPS  = 16;
   localparam int FRAC_SHIFT    = 30;

   // Rotation operands are one bit wider so that differences stay exact.
   localparam int OPERAND_BITS  = POSITION_BITS + 1;

   // CORDIC start vector length, the inverse gain in Q2.30.
   localparam logic signed [COEF_BITS-1:0] CORDIC_GAIN = 32'sd652032874;

   // Step angles atan(2^-i) as 32-bit binary angles.
   localparam logic signed [BAM_BITS-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
   };

   // Request commands.
   typedef enum logic [1:0] {
      CMD_TO_PARENT = 2'b00,
      CMD_TO_FRAME  = 2'b01,
      CMD_INVERT    = 2'b10,
      CMD_UNDEF     = 2'b11
   } cmd_type;

   // One request.
   typedef struct packed {
      cmd_type                         command;
      logic signed [POSITION_BITS-1:0] pose_x;
      logic signed [POSITION_BITS-1:0] pose_y;
      logic signed [ANGLE_BITS-1:0]    pose_angle;
      logic signed [POSITION_BITS-1:0] frame_x;
      logic signed [POSITION_BITS-1:0] frame_y;
      logic signed [ANGLE_BITS-1:0]    frame_angle;
   } req_type;

   // One result.
   typedef struct packed {
      logic signed [POSITION_BITS-1:0] out_x;
      logic signed [POSITION_BITS-1:0] out_y;
      logic signed [ANGLE_BITS-1:0]    out_angle;
      logic                            overflow;
   } rsp_type;

   // CORDIC vector and residual angle.
   typedef struct packed {
      logic signed [COEF_BITS-1:0] x;
      logic signed [COEF_BITS-1:0] y;
      logic signed [BAM_BITS-1:0]  z;
   } cord_type;

   // Request data that rides along the CORDIC chain.
   typedef struct packed {
      cmd_type                         cmd;
      logic signed [OPERAND_BITS-1:0]  a;
      logic signed [OPERAND_BITS-1:0]  b;
      logic signed [POSITION_BITS-1:0] off_x;
      logic signed [POSITION_BITS-1:0] off_y;
      logic [ANGLE_BITS-1:0]           angle;
      logic                            flip;
   } side_type;

endpackage

// ===== rtl/pft2d_front.sv =====
// Input stage: selects operands, output heading and the CORDIC start angle of a request.
`timescale 1ns / 1ps

module pft2d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  pft2d_pkg::req_type req_data,
   output logic               out_valid,
   output pft2d_pkg::side_type out_side,
   output pft2d_pkg::cord_type out_cord
);
   import pft2d_pkg::*;

   localparam int ZPAD = BAM_BITS - ANGLE_BITS;

   logic                   valid_ff;
   side_type               side_ff, side_in;
   cord_type               cord_ff, cord_in;
   logic [ANGLE_BITS-1:0]  rot_angle;
   logic [BAM_BITS-1:0]    bam;
   logic                   flip;
   logic signed [OPERAND_BITS-1:0] px_ext, py_ext, fx_ext, fy_ext;

   // Sign-extend the positions so that differences are exact.
   assign px_ext = $signed({req_data.pose_x[POSITION_BITS-1], req_data.pose_x});
   assign py_ext = $signed({req_data.pose_y[POSITION_BITS-1], req_data.pose_y});
   assign fx_ext = $signed({req_data.frame_x[POSITION_BITS-1], req_data.frame_x});
   assign fy_ext = $signed({req_data.frame_y[POSITION_BITS-1], req_data.frame_y});

   // Inversion rotates by the pose heading, the other commands by the frame heading.
   assign rot_angle = (req_data.command == CMD_INVERT) ? req_data.pose_angle
                                                       : req_data.frame_angle;
   assign bam  = {rot_angle, {ZPAD{1'b0}}};

   // Headings in the left half plane are turned by pi and the result negated later.
   assign flip = bam[BAM_BITS-1] ^ bam[BAM_BITS-2];

   // Operand selection per command.
   always_comb begin
      side_in       = '0;
      side_in.cmd   = req_data.command;
      side_in.flip  = flip;
      unique case (req_data.command)
         CMD_TO_PARENT: begin
            side_in.a     = px_ext;
            side_in.b     = py_ext;
            side_in.off_x = req_data.frame_x;
            side_in.off_y = req_data.frame_y;
            side_in.angle = req_data.pose_angle + req_data.frame_angle;
         end
         CMD_TO_FRAME: begin
            side_in.a     = px_ext - fx_ext;
            side_in.b     = py_ext - fy_ext;
            side_in.angle = req_data.pose_angle - req_data.frame_angle;
         end
         CMD_INVERT: begin
            side_in.a     = px_ext;
            side_in.b     = py_ext;
            side_in.angle = ANGLE_BITS'(0) - req_data.pose_angle;
         end
         CMD_UNDEF: begin
            side_in.a     = '0;
         end
      endcase
   end

   // CORDIC start vector.
   always_comb begin
      cord_in.x = CORDIC_GAIN;
      cord_in.y = '0;
      cord_in.z = $signed({bam[BAM_BITS-1] ^ flip, bam[BAM_BITS-2:0]});
   end

   // Valid flag is reset; data registers load on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         side_ff <= side_in;
         cord_ff <= cord_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_cord  = cord_ff;

endmodule

// ===== rtl/pft2d_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation step plus the request data it carries.
`timescale 1ns / 1ps

module pft2d_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pft2d_pkg::side_type in_side,
   input  pft2d_pkg::cord_type in_cord,
   output logic                out_valid,
   output pft2d_pkg::side_type out_side,
   output pft2d_pkg::cord_type out_cord
);
   import pft2d_pkg::*;

   logic                        valid_ff;
   side_type                    side_ff;
   cord_type                    cord_ff, cord_in;
   logic signed [COEF_BITS-1:0] dx, dy;
   logic                        turn_pos;

   // Arithmetic shifts floor toward minus infinity.
   assign dx       = $signed(in_cord.y) >>> STEP;
   assign dy       = $signed(in_cord.x) >>> STEP;
   assign turn_pos = ~in_cord.z[BAM_BITS-1];

   // Rotate toward zero residual angle.
   always_comb begin
      if (turn_pos) begin
         cord_in.x = in_cord.x - dx;
         cord_in.y = in_cord.y + dy;
         cord_in.z = in_cord.z - STEP_ANGLE[STEP];
      end else begin
         cord_in.x = in_cord.x + dx;
         cord_in.y = in_cord.y - dy;
         cord_in.z = in_cord.z + STEP_ANGLE[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= in_side;
      cord_ff <= cord_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_cord  = cord_ff;

endmodule

// ===== rtl/pft2d_backend.sv =====
// Back end: coefficient selection, split products, rounding, offset and saturation.
`timescale 1ns / 1ps

module pft2d_backend (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pft2d_pkg::side_type in_side,
   input  pft2d_pkg::cord_type in_cord,
   output logic                rsp_strobe,
   output pft2d_pkg::rsp_type  rsp_data
);
   import pft2d_pkg::*;

   localparam int SPLIT_BITS = OPERAND_BITS / 2;
   localparam int HI_BITS    = OPERAND_BITS - SPLIT_BITS;
   localparam int LO_PROD    = SPLIT_BITS + 1 + COEF_BITS;
   localparam int HI_PROD    = HI_BITS + COEF_BITS;
   localparam int FULL_BITS  = OPERAND_BITS + COEF_BITS;
   localparam int SUM_BITS   = FULL_BITS + 1;
   localparam int RND_BITS   = SUM_BITS - FRAC_SHIFT;
   localparam int TOT_BITS   = RND_BITS + 1;
   localparam int NPROD      = 4;

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
      $signed({{(SUM_BITS-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}});
   localparam logic signed [TOT_BITS-1:0] POS_MAX =
      $signed({{(TOT_BITS-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}});
   localparam logic signed [TOT_BITS-1:0] POS_MIN =
      $signed({{(TOT_BITS-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}});
   localparam logic signed [POSITION_BITS-1:0] OUT_MAX =
      $signed({1'b0, {(POSITION_BITS-1){1'b1}}});
   localparam logic signed [POSITION_BITS-1:0] OUT_MIN =
      $signed({1'b1, {(POSITION_BITS-1){1'b0}}});

   typedef struct packed {
      logic signed [COEF_BITS-1:0] kax;
      logic signed [COEF_BITS-1:0] kbx;
      logic signed [COEF_BITS-1:0] kay;
      logic signed [COEF_BITS-1:0] kby;
   } coef_type;

   function automatic logic signed [COEF_BITS-1:0] cond_neg(
      input logic signed [COEF_BITS-1:0] v,
      input logic                        neg
   );
      return neg ? -v : v;
   endfunction

   logic     v_n_ff, v_m1_ff, v_m2_ff, v_m3_ff, rsp_strobe_ff;
   side_type side_n_ff, side_m1_ff, side_m2_ff, side_m3_ff;
   coef_type coef_ff, coef_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   logic signed [OPERAND_BITS-1:0] op [NPROD];
   logic signed [COEF_BITS-1:0]    kk [NPROD];
   logic signed [LO_PROD-1:0]      plo_ff [NPROD], plo_in [NPROD];
   logic signed [HI_PROD-1:0]      phi_ff [NPROD], phi_in [NPROD];
   logic signed [FULL_BITS-1:0]    full_ff [NPROD], full_in [NPROD];
   logic signed [SUM_BITS-1:0]     sum_x, sum_y;
   logic signed [RND_BITS-1:0]     rx_ff, ry_ff;
   logic signed [TOT_BITS-1:0]     tx, ty;
   logic                           ovf_x, ovf_y;

   // Sine and cosine with the half-turn fold undone, signed per command.
   always_comb begin
      logic neg_c, neg_sx, neg_sy;
      neg_c  = 1'b0;
      neg_sx = 1'b0;
      neg_sy = 1'b0;
      unique case (in_side.cmd)
         CMD_TO_PARENT: neg_sx = 1'b1;
         CMD_TO_FRAME:  neg_sy = 1'b1;
         CMD_INVERT: begin
            neg_c  = 1'b1;
            neg_sx = 1'b1;
         end
         CMD_UNDEF:     neg_c  = 1'b0;
      endcase
      coef_in.kax = cond_neg(in_cord.x, in_side.flip ^ neg_c);
      coef_in.kbx = cond_neg(in_cord.y, in_side.flip ^ neg_sx);
      coef_in.kay = cond_neg(in_cord.y, in_side.flip ^ neg_sy);
      coef_in.kby = cond_neg(in_cord.x, in_side.flip ^ neg_c);
   end

   // Operand and coefficient of each of the four products.
   always_comb begin
      op[0] = side_n_ff.a;
      op[1] = side_n_ff.b;
      op[2] = side_n_ff.a;
      op[3] = side_n_ff.b;
      kk[0] = coef_ff.kax;
      kk[1] = coef_ff.kbx;
      kk[2] = coef_ff.kay;
      kk[3] = coef_ff.kby;
   end

   // Each product is split into a low unsigned and a high signed partial product.
   always_comb begin
      for (int j = 0; j < NPROD; j++) begin
         plo_in[j] = $signed({1'b0, op[j][SPLIT_BITS-1:0]}) * kk[j];
         phi_in[j] = $signed(op[j][OPERAND_BITS-1:SPLIT_BITS]) * kk[j];
      end
   end

   // Partial products recombined into exact full products.
   always_comb begin
      for (int j = 0; j < NPROD; j++) begin
         full_in[j] = $signed({phi_ff[j], {SPLIT_BITS{1'b0}}})
                    + $signed({{(FULL_BITS-LO_PROD){plo_ff[j][LO_PROD-1]}}, plo_ff[j]});
      end
   end

   // Dot products rounded half up and dropped to position scale.
   assign sum_x = $signed({full_ff[0][FULL_BITS-1], full_ff[0]})
                + $signed({full_ff[1][FULL_BITS-1], full_ff[1]}) + ROUND_HALF;
   assign sum_y = $signed({full_ff[2][FULL_BITS-1], full_ff[2]})
                + $signed({full_ff[3][FULL_BITS-1], full_ff[3]}) + ROUND_HALF;

   // Frame offset added, then clamped to the position range.
   assign tx = $signed({rx_ff[RND_BITS-1], rx_ff})
             + $signed({{(TOT_BITS-POSITION_BITS){side_m3_ff.off_x[POSITION_BITS-1]}},
                        side_m3_ff.off_x});
   assign ty = $signed({ry_ff[RND_BITS-1], ry_ff})
             + $signed({{(TOT_BITS-POSITION_BITS){side_m3_ff.off_y[POSITION_BITS-1]}},
                        side_m3_ff.off_y});

   always_comb begin
      ovf_x = 1'b0;
      ovf_y = 1'b0;
      priority if (tx > POS_MAX) begin
         rsp_data_in.out_x = OUT_MAX;
         ovf_x = 1'b1;
      end else if (tx < POS_MIN) begin
         rsp_data_in.out_x = OUT_MIN;
         ovf_x = 1'b1;
      end else begin
         rsp_data_in.out_x = tx[POSITION_BITS-1:0];
      end
      priority if (ty > POS_MAX) begin
         rsp_data_in.out_y = OUT_MAX;
         ovf_y = 1'b1;
      end else if (ty < POS_MIN) begin
         rsp_data_in.out_y = OUT_MIN;
         ovf_y = 1'b1;
      end else begin
         rsp_data_in.out_y = ty[POSITION_BITS-1:0];
      end
      rsp_data_in.out_angle = side_m3_ff.angle;
      rsp_data_in.overflow  = ovf_x | ovf_y;
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_n_ff        <= 1'b0;
         v_m1_ff       <= 1'b0;
         v_m2_ff       <= 1'b0;
         v_m3_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v_n_ff        <= in_valid;
         v_m1_ff       <= v_n_ff;
         v_m2_ff       <= v_m1_ff;
         v_m3_ff       <= v_m2_ff;
         rsp_strobe_ff <= v_m3_ff;
      end
   end

   // Data pipeline.
   always_ff @(posedge clock) begin
      side_n_ff  <= in_side;
      coef_ff    <= coef_in;
      side_m1_ff <= side_n_ff;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      side_m2_ff <= side_m1_ff;
      full_ff    <= full_in;
      side_m3_ff <= side_m2_ff;
      rx_ff      <= sum_x[SUM_BITS-1:FRAC_SHIFT];
      ry_ff      <= sum_y[SUM_BITS-1:FRAC_SHIFT];
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // A request in the first back-end stage passes the m1, m2 and m3 stages and then raises the strobe.
   a_strobe_latency: assert property (@(posedge clock) disable iff (reset)
      v_n_ff |-> ##4 rsp_strobe_ff)
      else $error("back end lost a request");

   // An undefined command gives an all-zero result.
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (v_m3_ff && side_m3_ff.cmd == CMD_UNDEF) |=> (rsp_data_ff == '0))
      else $error("undefined command gave a nonzero result");

   // The overflow flag comes only with a clamped position.
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_data_ff.overflow) |->
         (rsp_data_ff.out_x == OUT_MAX || rsp_data_ff.out_x == OUT_MIN ||
          rsp_data_ff.out_y == OUT_MAX || rsp_data_ff.out_y == OUT_MIN))
      else $error("overflow without a clamped position");

endmodule

// ===== rtl/pose_frame_transform_2d_core.sv =====
// Top level of the planar pose transform: input stage, CORDIC cell chain and back end.
// Pipeline: 1 input stage loaded at the edge that accepts a request, 16 CORDIC cells,
// and 5 back-end stages, the last of which drives the result strobe.
// Throughput: one request per cycle; busy is always low since every stage moves each cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous reset clears all valid flags; requests in flight are dropped, data is not reset.
`timescale 1ns / 1ps

module pose_frame_transform_2d_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pft2d_pkg::req_type req_data,
   output logic               rsp_strobe,
   output pft2d_pkg::rsp_type rsp_data
);
   import pft2d_pkg::*;

   logic     take;
   logic     chain_valid [CORDIC_STEPS+1];
   side_type chain_side  [CORDIC_STEPS+1];
   cord_type chain_cord  [CORDIC_STEPS+1];

   // Every stage advances each cycle, so a request is always taken.
   assign busy = 1'b0;
   assign take = start & ~busy;

   pft2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_data  (req_data),
      .out_valid (chain_valid[0]),
      .out_side  (chain_side[0]),
      .out_cord  (chain_cord[0])
   );

   // Row of CORDIC cells, one micro-rotation each.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      pft2d_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_side   (chain_side[i]),
         .in_cord   (chain_cord[i]),
         .out_valid (chain_valid[i+1]),
         .out_side  (chain_side[i+1]),
         .out_cord  (chain_cord[i+1])
      );
   end

   pft2d_backend u_backend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[CORDIC_STEPS]),
      .in_side    (chain_side[CORDIC_STEPS]),
      .in_cord    (chain_cord[CORDIC_STEPS]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
